FILE: design/bfz_pkg.sv
// ----------------------------------------------------------------------------
// bfz_pkg
// Shared types and constants for the zero-padded box filter.
// ----------------------------------------------------------------------------
package bfz_pkg;

  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int KS_W       = 3;
  localparam int RAD_W      = 2;
  localparam int ROW_W      = 11;
  localparam int MAX_HEIGHT = 1024;

  // The kernel_size register is three bits wide, so a window never has more
  // than seven rows or columns.
  localparam int CELL_MAX = 7;

  // One column of up to seven pixels, and the whole window of up to 49.
  localparam int CSUM_W = 11;
  localparam int SUM_W  = 14;

  // floor(sum / area) = (sum * RECIP_TBL[radius]) >> RECIP_SH, exact for any
  // sum below 2**SUM_W.
  localparam int RECIP_W  = 21;
  localparam int RECIP_SH = 20;
  localparam logic [RECIP_W-1:0] RECIP_TBL [4] = '{
    RECIP_W'((2**RECIP_SH + 0) / 1),
    RECIP_W'((2**RECIP_SH + 8) / 9),
    RECIP_W'((2**RECIP_SH + 24) / 25),
    RECIP_W'((2**RECIP_SH + 48) / 49)
  };

  typedef logic [PIX_W-1:0] pixel_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KERNEL_SIZE  = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_reg_t;

endpackage

FILE: design/bfz_line_bank.sv
// ----------------------------------------------------------------------------
// bfz_line_bank
// One row bank of the line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module bfz_line_bank #(
  parameter int DEPTH = 1027,
  parameter int AW    = 11
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  bfz_pkg::pixel_t     wr_data,
  input  logic                rd_en,
  input  logic [AW-1:0]       rd_addr,
  output bfz_pkg::pixel_t     rd_data
);
  import bfz_pkg::*;

  pixel_t mem [DEPTH];
  pixel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/bfz_cell.sv
// ----------------------------------------------------------------------------
// bfz_cell
// One window column: holds a column of pixels, passes it to the next cell on
// every shift, and forms the masked column sum for the current output.
// ----------------------------------------------------------------------------
module bfz_cell #(
  parameter int NC = 7
) (
  input  logic                              clk,
  input  logic                              shift_en,
  input  bfz_pkg::pixel_t [NC-1:0]          col_in,
  output bfz_pkg::pixel_t [NC-1:0]          col_out,
  input  logic [NC-1:0]                     row_mask,
  input  logic                              col_en,
  input  logic                              sum_en,
  output logic [bfz_pkg::CSUM_W-1:0]        col_sum
);
  import bfz_pkg::*;

  pixel_t [NC-1:0]   pix_r;
  logic [CSUM_W-1:0] csum_c;
  logic [CSUM_W-1:0] col_sum_r;

  // Element 0 is the newest row, element m the row m lines above it.
  always_ff @(posedge clk) begin
    if (shift_en) begin
      pix_r <= col_in;
    end
  end

  always_comb begin
    csum_c = '0;
    for (int m = 0; m < NC; m++) begin
      if (row_mask[m]) begin
        csum_c = csum_c + CSUM_W'(pix_r[m]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sum_en) begin
      col_sum_r <= col_en ? csum_c : '0;
    end
  end

  assign col_out = pix_r;
  assign col_sum = col_sum_r;

endmodule

FILE: design/box_filter_zero_pad_unit.sv
// A result beat passes from stage 1 through the cell chain, the column sums and the window sum to the output register.
// One input beat per cycle is sustained while out_ready does not hold the pipeline;
// every row bank is read and one bank is written per accepted beat, and the column cells shift once per beat.
// Beats in the first radius rows or columns of the extended frame give no result.
// rst_n (synchronous, active low) clears the position counters and pipeline valids
// and loads kernel_size 3, image_width 640, image_height 480; the store is not cleared.
// ----------------------------------------------------------------------------
// box_filter_zero_pad_unit
// Streaming k-by-k mean filter with zero padding, built from a line store and
// a chain of window column cells followed by an adder and reciprocal multiply.
// ----------------------------------------------------------------------------
module box_filter_zero_pad_unit #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_KERNEL = 7
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bfz_pkg::pixel_t                     in_pixel_in,
  input  logic                                in_is_fill,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bfz_pkg::pixel_t                     out_pixel_out,
  output logic                                out_frame_end,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bfz_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bfz_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bfz_pkg::*;

  localparam int NB         = MAX_KERNEL;
  localparam int KODD       = (MAX_KERNEL - 1) | 1;
  localparam int NC         = (KODD > CELL_MAX) ? CELL_MAX : KODD;
  localparam int STORE_COLS = MAX_WIDTH + MAX_KERNEL / 2;
  localparam int AW         = $clog2(STORE_COLS);
  localparam int COL_W0     = $clog2(STORE_COLS + 1);
  localparam int XW         = (COL_W0 > CFG_DATA_W) ? COL_W0 : CFG_DATA_W;
  localparam int BW         = $clog2(NB);

  function automatic logic [BW-1:0] bank_inc(input logic [BW-1:0] b);
    return (b == BW'(NB - 1)) ? '0 : b + 1'b1;
  endfunction

  // Bank holding the row m lines above the row in bank b.
  function automatic logic [BW-1:0] rot_idx(input logic [BW-1:0] b, input int m);
    logic [BW:0] t;
    t = {1'b0, b} + (BW+1)'(NB - m);
    if (t >= (BW+1)'(NB)) begin
      t = t - (BW+1)'(NB);
    end
    return t[BW-1:0];
  endfunction

  // Configuration registers
  logic [KS_W-1:0]       kernel_size_r;
  logic [CFG_DATA_W-1:0] image_width_r;
  logic [CFG_DATA_W-1:0] image_height_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_size_r  <= KS_W'(3);
      image_width_r  <= CFG_DATA_W'(640);
      image_height_r <= CFG_DATA_W'(480);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        CFG_KERNEL_SIZE:  kernel_size_r  <= cfg_data[KS_W-1:0];
        CFG_IMAGE_WIDTH:  image_width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT: image_height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective geometry
  logic [KS_W-1:0]  k_odd;
  logic [KS_W-1:0]  k_eff;
  logic [RAD_W-1:0] rad;
  logic [KS_W-1:0]  two_rad;
  logic [XW-1:0]    w_raw;
  logic [XW-1:0]    w_eff;
  logic [ROW_W-1:0] h_eff;
  logic [XW-1:0]    ew;
  logic [ROW_W-1:0] eh;

  always_comb begin
    k_odd   = kernel_size_r | KS_W'(1);
    k_eff   = (k_odd > KS_W'(NC)) ? KS_W'(NC) : k_odd;
    rad     = k_eff[KS_W-1:1];
    two_rad = k_eff - KS_W'(1);
    w_raw   = XW'(image_width_r);
    if (image_width_r == '0) begin
      w_eff = XW'(1);
    end else if (w_raw > XW'(MAX_WIDTH)) begin
      w_eff = XW'(MAX_WIDTH);
    end else begin
      w_eff = w_raw;
    end
    if (image_height_r == '0) begin
      h_eff = ROW_W'(1);
    end else if (image_height_r > ROW_W'(MAX_HEIGHT)) begin
      h_eff = ROW_W'(MAX_HEIGHT);
    end else begin
      h_eff = image_height_r;
    end
    ew = w_eff + XW'(rad);
    eh = h_eff + ROW_W'(rad);
  end

  // Pipeline handshake
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic ready_o, ready1, ready2, ready3, ready4;
  logic adv1, adv2, adv3, adv4;
  logic acc;

  assign ready_o = !out_valid_r || out_ready;
  assign adv4    = v4_r && ready_o;
  assign ready4  = !v4_r || ready_o;
  assign adv3    = v3_r && ready4;
  assign ready3  = !v3_r || ready4;
  assign adv2    = v2_r && ready3;
  assign ready2  = !v2_r || ready3;
  assign adv1    = v1_r && ready2;
  assign ready1  = !v1_r || ready2;
  assign in_ready = ready1;
  assign acc      = in_valid && in_ready;

  // Position in the extended frame. A geometry change can leave the counters
  // past the frame, so they are folded back before use.
  logic [XW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [BW-1:0]    bank_r, bank_nxt;
  logic             col_wrap, row_wrap;
  logic [ROW_W-1:0] r_a, cur_r, r_n;
  logic [XW-1:0]    c_a, cur_c, c_n;
  logic [BW-1:0]    b_a, cur_b;

  always_comb begin
    col_wrap = col_r >= ew;
    r_a      = col_wrap ? row_r + 1'b1 : row_r;
    b_a      = col_wrap ? bank_inc(bank_r) : bank_r;
    c_a      = col_wrap ? '0 : col_r;
    row_wrap = r_a >= eh;
    cur_r    = row_wrap ? '0 : r_a;
    cur_c    = row_wrap ? '0 : c_a;
    cur_b    = row_wrap ? '0 : b_a;

    c_n      = cur_c + 1'b1;
    r_n      = cur_r + 1'b1;
    col_nxt  = col_r;
    row_nxt  = row_r;
    bank_nxt = bank_r;
    if (acc) begin
      if (c_n >= ew) begin
        col_nxt = '0;
        if (r_n >= eh) begin
          row_nxt  = '0;
          bank_nxt = '0;
        end else begin
          row_nxt  = r_n;
          bank_nxt = bank_inc(cur_b);
        end
      end else begin
        col_nxt  = c_n;
        row_nxt  = cur_r;
        bank_nxt = cur_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      bank_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      bank_r <= bank_nxt;
    end
  end

  // Per-beat decode: stored value, window masks, result flags
  pixel_t        val_c;
  logic [NC-1:0] rowm_c, colm_c;
  logic          has_out_c, fe_c;

  always_comb begin
    val_c = (in_is_fill || cur_r >= h_eff || cur_c >= w_eff) ? '0 : in_pixel_in;
    has_out_c = (cur_r >= ROW_W'(rad)) && (cur_c >= XW'(rad));
    fe_c = (cur_r == eh - 1'b1) && (cur_c == ew - 1'b1);
    for (int m = 0; m < NC; m++) begin
      rowm_c[m] = (KS_W'(m) <= two_rad) && (cur_r >= ROW_W'(m)) &&
                  ({1'b0, cur_r} < ({1'b0, h_eff} + (ROW_W+1)'(m)));
      colm_c[m] = (KS_W'(m) <= two_rad) && (cur_c >= XW'(m)) &&
                  ({1'b0, cur_c} < ({1'b0, w_eff} + (XW+1)'(m)));
    end
  end

  // Line store: one bank per row slot, all read at the current column
  pixel_t rd_data [NB];

  for (genvar g = 0; g < NB; g++) begin : g_bank
    bfz_line_bank #(
      .DEPTH (STORE_COLS),
      .AW    (AW)
    ) u_bank (
      .clk     (clk),
      .wr_en   (acc && (cur_b == BW'(g))),
      .wr_addr (cur_c[AW-1:0]),
      .wr_data (val_c),
      .rd_en   (acc),
      .rd_addr (cur_c[AW-1:0]),
      .rd_data (rd_data[g])
    );
  end

  // Stage 1: waiting for the store read
  logic          has1_r, fe1_r;
  pixel_t        val1_r;
  logic [BW-1:0] b1_r;
  logic [NC-1:0] rowm1_r, colm1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (acc) begin
      v1_r <= 1'b1;
    end else if (adv1) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      has1_r  <= has_out_c;
      fe1_r   <= fe_c;
      val1_r  <= val_c;
      b1_r    <= cur_b;
      rowm1_r <= rowm_c;
      colm1_r <= colm_c;
    end
  end

  // New column for the head cell, newest row first
  pixel_t [NC-1:0] col_new;

  always_comb begin
    col_new[0] = val1_r;
    for (int m = 1; m < NC; m++) begin
      col_new[m] = rd_data[rot_idx(b1_r, m)];
    end
  end

  // Stage 2: the beat's column sits in cell 0; cell d holds column c-d
  logic          fe2_r;
  logic [NC-1:0] rowm2_r, colm2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv1) begin
      v2_r <= has1_r;
    end else if (adv2) begin
      v2_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      fe2_r   <= fe1_r;
      rowm2_r <= rowm1_r;
      colm2_r <= colm1_r;
    end
  end

  pixel_t [NC-1:0]   chain [NC];
  logic [CSUM_W-1:0] csum [NC];

  for (genvar g = 0; g < NC; g++) begin : g_cell
    if (g == 0) begin : g_head
      bfz_cell #(.NC(NC)) u_cell (
        .clk      (clk),
        .shift_en (adv1),
        .col_in   (col_new),
        .col_out  (chain[g]),
        .row_mask (rowm2_r),
        .col_en   (colm2_r[g]),
        .sum_en   (adv2),
        .col_sum  (csum[g])
      );
    end else begin : g_body
      bfz_cell #(.NC(NC)) u_cell (
        .clk      (clk),
        .shift_en (adv1),
        .col_in   (chain[g-1]),
        .col_out  (chain[g]),
        .row_mask (rowm2_r),
        .col_en   (colm2_r[g]),
        .sum_en   (adv2),
        .col_sum  (csum[g])
      );
    end
  end

  // Stage 3: column sums held in the cells
  logic fe3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv2) begin
      v3_r <= 1'b1;
    end else if (adv3) begin
      v3_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      fe3_r <= fe2_r;
    end
  end

  // Stage 4: window sum
  logic [SUM_W-1:0] sum_c, sum4_r;
  logic             fe4_r;

  always_comb begin
    sum_c = '0;
    for (int g = 0; g < NC; g++) begin
      sum_c = sum_c + SUM_W'(csum[g]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (adv3) begin
      v4_r <= 1'b1;
    end else if (adv4) begin
      v4_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      sum4_r <= sum_c;
      fe4_r  <= fe3_r;
    end
  end

  // Output register: mean by reciprocal multiply
  logic [SUM_W+RECIP_W-1:0] prod_c;
  pixel_t                   pixel_out_r;
  logic                     frame_end_r;

  assign prod_c = (SUM_W+RECIP_W)'(sum4_r) * (SUM_W+RECIP_W)'(RECIP_TBL[rad]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv4) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      pixel_out_r <= prod_c[RECIP_SH +: PIX_W];
      frame_end_r <= fe4_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_pixel_out = pixel_out_r;
  assign out_frame_end = frame_end_r;

  // Assertions
  a_bank_row0: assert property (@(posedge clk) disable iff (!rst_n)
    (row_r == '0) |-> (bank_r == '0))
    else $error("line store bank pointer out of step with row counter");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !ready3) |=> $stable(chain[0]))
    else $error("cell chain shifted under a stalled window");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v4_r))
    else $error("result beat without a summed window behind it");

  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> v1_r)
    else $error("accepted beat lost before the store read");

endmodule
